// ----- hdl/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int unsigned BoxCapacity = 256;
    localparam int unsigned KeepMax     = 16;
    localparam logic [15:0] IouLimitRst = 16'd19661;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SEL_RD,
        ST_SEL_WAIT,
        ST_CHK_RD,
        ST_CHK_WAIT,
        ST_CHK_MUL,
        ST_CHK_CMP,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // write incoming box
        logic sort_init;   // i = 0
        logic sort_start;  // box read address = i
        logic sort_rd;     // read order[j-1]
        logic sort_shift;  // order[j] = order[j-1], j--
        logic sort_place;  // order[j] = i, i++
        logic sel_init;
        logic sel_rd;      // read order[i]
        logic sel_cand;    // latch candidate corners
        logic chk_rd;      // read kept[k]
        logic chk_area;    // compute widths, heights
        logic chk_mul;     // products
        logic chk_next;    // k++
        logic keep;        // append candidate
        logic sel_next;    // i++, k=0
        logic out_init;
        logic out_rd;
        logic out_load;    // load output register
        logic out_next;
        logic finish;      // clear set
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_is_last;
        logic sort_done;    // i == n
        logic sort_j_zero;
        logic sort_less;    // score(order[j-1]) < score(i)
        logic sel_done;     // i == n or kept full
        logic chk_done;     // k == kept_count
        logic overlap;
        logic out_done;     // last kept emitted
    } t_sts;

endpackage

// ----- hdl/gbs_if.sv -----
// ----------------------------------------------------------------------------
// gbs_box_if / gbs_kept_if
// Valid/ready channels for loaded candidates and kept results.
// ----------------------------------------------------------------------------
interface gbs_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] corner_ax;
    logic signed [15:0] corner_ay;
    logic signed [15:0] corner_bx;
    logic signed [15:0] corner_by;
    logic        [15:0] box_score;
    logic signed [15:0] box_angle;
    logic               load_last;
    modport source (output valid, corner_ax, corner_ay, corner_bx, corner_by,
                    box_score, box_angle, load_last, input ready);
    modport sink   (input valid, corner_ax, corner_ay, corner_bx, corner_by,
                    box_score, box_angle, load_last, output ready);
endinterface

interface gbs_kept_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_ax;
    logic signed [15:0] out_ay;
    logic signed [15:0] out_bx;
    logic signed [15:0] out_by;
    logic        [15:0] out_score;
    logic signed [15:0] out_angle;
    logic               overflow;
    logic               out_last;
    modport source (output valid, out_ax, out_ay, out_bx, out_by, out_score,
                    out_angle, overflow, out_last, input ready);
    modport sink   (input valid, out_ax, out_ay, out_bx, out_by, out_score,
                    out_angle, overflow, out_last, output ready);
endinterface

// ----- hdl/gbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer for load, insertion sort, suppression walk and result output.
// ----------------------------------------------------------------------------
module gbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gbs_pkg::t_sts i_sts,
    output gbs_pkg::t_cmd o_cmd,
    output gbs_pkg::t_state o_state
);
    import gbs_pkg::*;

    t_state r_state, n_state;
    logic   w_out_xfer;

    assign w_out_xfer = (r_state == ST_OUT_HOLD) && i_out_ready;
    assign o_state    = r_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:     if (i_in_valid && i_sts.load_is_last) n_state = ST_SORT_RD;
            ST_SORT_RD:  if (i_sts.sort_done) n_state = ST_SEL_RD;
                         else if (i_sts.sort_j_zero) n_state = ST_SORT_RD;
                         else n_state = ST_SORT_CMP;
            ST_SORT_CMP: n_state = ST_SORT_RD;
            ST_SEL_RD:   if (i_sts.sel_done) n_state = ST_OUT_RD;
                         else n_state = ST_SEL_WAIT;
            ST_SEL_WAIT: n_state = ST_CHK_RD;
            ST_CHK_RD:   if (i_sts.chk_done) n_state = ST_SEL_RD;
                         else n_state = ST_CHK_WAIT;
            ST_CHK_WAIT: n_state = ST_CHK_MUL;
            ST_CHK_MUL:  n_state = ST_CHK_CMP;
            ST_CHK_CMP:  if (i_sts.overlap) n_state = ST_SEL_RD;
                         else n_state = ST_CHK_RD;
            ST_OUT_RD:   n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: n_state = ST_OUT_HOLD;
            ST_OUT_HOLD: if (i_out_ready) begin
                             n_state = i_sts.out_done ? ST_LOAD : ST_OUT_RD;
                         end
            default:     n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.load_is_last) o_cmd.sort_init = 1'b1;
                end
            end
            ST_SORT_RD: begin
                // in this state the sort scans j down; j==0 places i, else order[j-1] is read
                if (i_sts.sort_done) begin
                    o_cmd.sel_init = 1'b1;
                end else if (i_sts.sort_j_zero) begin
                    o_cmd.sort_place = 1'b1;
                end else begin
                    o_cmd.sort_rd = 1'b1;
                end
            end
            ST_SORT_CMP: begin
                if (i_sts.sort_less) o_cmd.sort_shift = 1'b1;
                else                 o_cmd.sort_place = 1'b1;
            end
            ST_SEL_RD: begin
                if (i_sts.sel_done) o_cmd.out_init = 1'b1;
                else                o_cmd.sel_rd = 1'b1;
            end
            ST_SEL_WAIT: o_cmd.sel_cand = 1'b1;
            ST_CHK_RD: begin
                if (i_sts.chk_done) begin
                    o_cmd.keep     = 1'b1;
                    o_cmd.sel_next = 1'b1;
                end else begin
                    o_cmd.chk_rd = 1'b1;
                end
            end
            ST_CHK_WAIT: o_cmd.chk_area = 1'b1;
            ST_CHK_MUL:  o_cmd.chk_mul  = 1'b1;
            ST_CHK_CMP: begin
                if (i_sts.overlap) o_cmd.sel_next = 1'b1;
                else               o_cmd.chk_next = 1'b1;
            end
            ST_OUT_RD:   o_cmd.out_rd   = 1'b1;
            ST_OUT_WAIT: o_cmd.out_load = 1'b1;
            ST_OUT_HOLD: begin
                o_out_valid = 1'b1;
                if (w_out_xfer) begin
                    o_cmd.out_next = 1'b1;
                    if (i_sts.out_done) o_cmd.finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/gbs_datapath.sv -----
// ----------------------------------------------------------------------------
// gbs_datapath
// Box stores, sort order memory, kept list and the IoU test unit.
// ----------------------------------------------------------------------------
module gbs_datapath #(
    parameter int unsigned BOX_CAPACITY = gbs_pkg::BoxCapacity,
    parameter int unsigned KEEP_MAX     = gbs_pkg::KeepMax
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_iou_limit,
    input  logic [95:0]   i_box,
    input  logic          i_last,
    input  gbs_pkg::t_cmd i_cmd,
    output gbs_pkg::t_sts o_sts,
    output logic [97:0]   o_result
);
    import gbs_pkg::*;

    localparam int unsigned AW = $clog2(BOX_CAPACITY);
    localparam int unsigned CW = $clog2(BOX_CAPACITY + 1);
    localparam int unsigned KA = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
    localparam int unsigned KW = $clog2(KEEP_MAX + 1);
    // order entry: score above, box index below
    localparam int unsigned OW = AW + 16;

    // memories
    logic [95:0]   r_box_mem [BOX_CAPACITY];
    logic [OW-1:0] r_ord_mem [BOX_CAPACITY];
    logic [AW-1:0] r_kept    [KEEP_MAX];

    logic [CW-1:0] r_load_cnt, r_n, r_i, r_j;
    logic          r_drop;
    logic [KW-1:0] r_kept_cnt, r_k;
    logic [15:0]   r_key;
    logic [OW-1:0] r_ord_rd;
    logic [95:0]   r_box_rd;
    logic [AW-1:0] r_cand;
    logic [63:0]   r_cand_box;
    logic          r_mem_sel;

    // read address muxing
    logic [AW-1:0] w_box_addr;
    logic [AW-1:0] w_ord_addr;
    logic [CW-1:0] w_jm1;
    assign w_jm1 = r_j - CW'(1);

    always_comb begin
        w_ord_addr = w_jm1[AW-1:0];
        if (i_cmd.sel_rd) w_ord_addr = r_i[AW-1:0];
        w_box_addr = r_i[AW-1:0];
        if (r_mem_sel) w_box_addr = r_ord_rd[AW-1:0];
        if (i_cmd.chk_rd) w_box_addr = r_kept[r_k[KA-1:0]];
        if (i_cmd.out_rd) w_box_addr = r_kept[r_k[KA-1:0]];
        if (i_cmd.sort_start) w_box_addr = r_i[AW-1:0];
    end

    // box store write and read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_load_cnt < CW'(BOX_CAPACITY))) begin
            r_box_mem[r_load_cnt[AW-1:0]] <= i_box;
        end
        r_box_rd <= r_box_mem[w_box_addr];
    end

    // order store write and read; each entry carries its score as sort key
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_shift) r_ord_mem[r_j[AW-1:0]] <= r_ord_rd;
        else if (i_cmd.sort_place) r_ord_mem[r_j[AW-1:0]] <= {r_key, r_i[AW-1:0]};
        r_ord_rd <= r_ord_mem[w_ord_addr];
    end

    // key of i
    logic [15:0]   r_key_mem [BOX_CAPACITY];
    logic [AW-1:0] n_i_addr;
    always_comb begin
        n_i_addr = r_i[AW-1:0];
        if (i_cmd.sort_place) n_i_addr = AW'(r_i + CW'(1));
        if (i_cmd.sort_init)  n_i_addr = '0;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_load_cnt < CW'(BOX_CAPACITY))) begin
            r_key_mem[r_load_cnt[AW-1:0]] <= i_box[79:64];
        end
        r_key <= r_key_mem[n_i_addr];
    end
    assign r_mem_sel = 1'b0;

    // counters and control registers
    logic w_place_j_zero;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_drop     <= 1'b0;
            r_kept_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_n        <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_load_cnt < CW'(BOX_CAPACITY)) r_load_cnt <= r_load_cnt + CW'(1);
                else                               r_drop     <= 1'b1;
            end
            if (i_cmd.sort_init) begin
                r_i <= '0;
                r_j <= '0;
                r_n <= (r_load_cnt < CW'(BOX_CAPACITY)) ? r_load_cnt + CW'(1)
                                                       : r_load_cnt;
            end
            if (i_cmd.sort_shift) r_j <= w_jm1;
            if (i_cmd.sort_place) begin
                r_i <= r_i + CW'(1);
                r_j <= r_i + CW'(1);
            end
            if (i_cmd.sel_init) begin
                r_i <= '0;
                r_k <= '0;
                r_kept_cnt <= '0;
            end
            if (i_cmd.chk_next) r_k <= r_k + KW'(1);
            if (i_cmd.keep) begin
                r_kept[r_kept_cnt[KA-1:0]] <= r_cand;
                r_kept_cnt <= r_kept_cnt + KW'(1);
            end
            if (i_cmd.sel_next) begin
                r_i <= r_i + CW'(1);
                r_k <= '0;
            end
            if (i_cmd.out_init) r_k <= '0;
            if (i_cmd.out_next) r_k <= r_k + KW'(1);
            if (i_cmd.finish) begin
                r_load_cnt <= '0;
                r_drop     <= 1'b0;
                r_kept_cnt <= '0;
            end
        end
    end

    // candidate capture (order read arrives in the cycle after sel_rd)
    logic [95:0] r_cbox_rd;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_cand) begin
            r_cand    <= r_ord_rd[AW-1:0];
            r_cbox_rd <= r_box_mem[r_ord_rd[AW-1:0]];
        end
        if (i_cmd.chk_rd) r_cand_box <= r_cbox_rd[63:0];
    end

    // IoU stage 1: bounds, widths, heights
    function automatic logic signed [15:0] smin(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a < b) ? a : b;
    endfunction
    function automatic logic signed [15:0] smax(input logic signed [15:0] a,
                                                input logic signed [15:0] b);
        return (a > b) ? a : b;
    endfunction

    logic signed [15:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [17:0] w_iw, w_ih;
    always_comb begin
        ax0 = smin(r_cand_box[15:0],  r_cand_box[47:32]);
        ax1 = smax(r_cand_box[15:0],  r_cand_box[47:32]);
        ay0 = smin(r_cand_box[31:16], r_cand_box[63:48]);
        ay1 = smax(r_cand_box[31:16], r_cand_box[63:48]);
        bx0 = smin(r_box_rd[15:0],  r_box_rd[47:32]);
        bx1 = smax(r_box_rd[15:0],  r_box_rd[47:32]);
        by0 = smin(r_box_rd[31:16], r_box_rd[63:48]);
        by1 = smax(r_box_rd[31:16], r_box_rd[63:48]);
        w_iw = 18'(smin(ax1, bx1)) - 18'(smax(ax0, bx0));
        w_ih = 18'(smin(ay1, by1)) - 18'(smax(ay0, by0));
    end

    logic [16:0] r_aw, r_ah, r_bw, r_bh, r_iw, r_ih;
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_area) begin
            r_aw <= 17'(18'(ax1) - 18'(ax0));
            r_ah <= 17'(18'(ay1) - 18'(ay0));
            r_bw <= 17'(18'(bx1) - 18'(bx0));
            r_bh <= 17'(18'(by1) - 18'(by0));
            r_iw <= w_iw[17] ? 17'd0 : w_iw[16:0];
            r_ih <= w_ih[17] ? 17'd0 : w_ih[16:0];
        end
    end

    // IoU stage 2: three area products
    logic [33:0] r_area0, r_area1, r_inter;
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_mul) begin
            r_area0 <= r_aw * r_ah;
            r_area1 <= r_bw * r_bh;
            r_inter <= r_iw * r_ih;
        end
    end

    // IoU stage 3: union and cross-multiplied compare
    logic [34:0] w_union;
    logic [50:0] w_lhs, w_rhs;
    logic        w_overlap;
    assign w_union = 35'(r_area0) + 35'(r_area1) - 35'(r_inter);
    assign w_lhs   = {1'b0, r_inter, 16'd0};
    assign w_rhs   = 51'(i_iou_limit) * 51'(w_union);
    always_comb begin
        if ((r_area0 == '0) || (r_area1 == '0)) w_overlap = (i_iou_limit == '0);
        else w_overlap = (w_lhs >= w_rhs);
    end

    // output payload
    logic [95:0] r_out_box;
    logic        r_out_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_box  <= r_box_rd;
            r_out_last <= (r_k + KW'(1) == r_kept_cnt);
        end
    end
    assign o_result = {r_out_last, r_drop, r_out_box};

    // status
    assign w_place_j_zero = (r_j == '0);
    always_comb begin
        o_sts              = '0;
        o_sts.load_is_last = i_last;
        o_sts.sort_done    = (r_i == r_n);
        o_sts.sort_j_zero  = w_place_j_zero;
        o_sts.sort_less    = (r_ord_rd[OW-1:AW] < r_key);
        o_sts.sel_done     = (r_i == r_n) || (r_kept_cnt == KW'(KEEP_MAX));
        o_sts.chk_done     = (r_k == r_kept_cnt);
        o_sts.overlap      = w_overlap;
        o_sts.out_done     = (r_k + KW'(1) == r_kept_cnt);
    end

endmodule

// ----- hdl/greedy_box_suppression_core.sv -----
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy IoU suppression over a loaded set of candidate boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Candidates arrive on i_box (valid/ready), one transfer per cycle while
//   loading. load_last closes the set; ready then drops until the results
//   are all out. Up to BOX_CAPACITY boxes are stored, later ones are dropped
//   and reported through overflow.
//   The set is insertion-sorted by descending score, then walked in score
//   order: each candidate is tested against the kept boxes in turn through
//   the area multipliers and is kept when none of them overlaps it; the
//   walk ends once KEEP_MAX boxes are kept.
//   Kept boxes leave on o_kept (1 to KEEP_MAX transfers), one at a time;
//   a stalled receiver holds the output register and the sequencer.
//   Reset clears counters and returns to loading; iou_limit resets to its
//   default and is written through i_cfg_we / i_cfg_data; the user must
//   write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module greedy_box_suppression_core #(
    parameter int unsigned BOX_CAPACITY = gbs_pkg::BoxCapacity,
    parameter int unsigned KEEP_MAX     = gbs_pkg::KeepMax
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    gbs_box_if.sink     i_box,
    gbs_kept_if.source  o_kept
);
    import gbs_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    t_state      w_state;
    logic [97:0] w_result;
    logic [15:0] r_iou_limit;

    // hold threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_limit <= IouLimitRst;
        end else if (i_cfg_we) begin
            r_iou_limit <= i_cfg_data;
        end
    end

    gbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_box.valid),
        .o_in_ready  (i_box.ready),
        .o_out_valid (o_kept.valid),
        .i_out_ready (o_kept.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    gbs_datapath #(
        .BOX_CAPACITY (BOX_CAPACITY),
        .KEEP_MAX     (KEEP_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iou_limit (r_iou_limit),
        .i_box       ({i_box.box_angle, i_box.box_score, i_box.corner_by,
                       i_box.corner_bx, i_box.corner_ay, i_box.corner_ax}),
        .i_last      (i_box.load_last),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (w_result)
    );

    assign o_kept.out_ax    = w_result[15:0];
    assign o_kept.out_ay    = w_result[31:16];
    assign o_kept.out_bx    = w_result[47:32];
    assign o_kept.out_by    = w_result[63:48];
    assign o_kept.out_score = w_result[79:64];
    assign o_kept.out_angle = w_result[95:80];
    assign o_kept.overflow  = w_result[96];
    assign o_kept.out_last  = w_result[97];

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_box.ready && o_kept.valid))
        else $error("input ready while result pending");

    // results only appear after the output register was loaded
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_kept.valid) |-> $past(w_cmd.out_load))
        else $error("result shown without load");

    // keep and chk_next never together
    a_keep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.keep && w_cmd.chk_next))
        else $error("keep during check");

    // sequencer is in load state whenever input is ready
    a_ready_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box.ready |-> (w_state == ST_LOAD))
        else $error("ready outside load");

endmodule

// ----- verif/tb_greedy_box_suppression_core.sv -----
// ----------------------------------------------------------------------------
// tb_greedy_box_suppression_core
// Loads candidate sets of boxes, predicts the kept boxes by greedy IoU
// suppression in a scoreboard, and checks every transfer on the result side.
// ----------------------------------------------------------------------------
module tb_greedy_box_suppression_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic        [15:0] score;
        logic signed [15:0] angle;
        logic               last;
    } t_box;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic        [15:0] score;
        logic signed [15:0] angle;
        logic               overflow;
        logic               last;
    } t_kept;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the current set and the kept boxes still to arrive
    // ------------------------------------------------------------------------
    class nms_scoreboard;
        t_box        set_boxes[$];
        t_kept       kept_due[$];
        logic [15:0] iou_limit;
        bit          dropped;
        int          errors;
        int          sets_closed;
        int          kept_seen;

        function new();
            iou_limit   = IouLimitRst;
            dropped     = 0;
            errors      = 0;
            sets_closed = 0;
            kept_seen   = 0;
        endfunction

        // True when the IoU of two boxes reaches the limit
        function bit suppresses(t_box p, t_box q);
            int     px0, px1, py0, py1, qx0, qx1, qy0, qy1, iw, ih;
            longint area_p, area_q, inter, uni;
            px0 = (p.ax < p.bx) ? p.ax : p.bx;  px1 = (p.ax < p.bx) ? p.bx : p.ax;
            py0 = (p.ay < p.by) ? p.ay : p.by;  py1 = (p.ay < p.by) ? p.by : p.ay;
            qx0 = (q.ax < q.bx) ? q.ax : q.bx;  qx1 = (q.ax < q.bx) ? q.bx : q.ax;
            qy0 = (q.ay < q.by) ? q.ay : q.by;  qy1 = (q.ay < q.by) ? q.by : q.ay;
            area_p = longint'(px1 - px0) * longint'(py1 - py0);
            area_q = longint'(qx1 - qx0) * longint'(qy1 - qy0);
            if (area_p == 0 || area_q == 0) return iou_limit == 0;
            iw = ((px1 < qx1) ? px1 : qx1) - ((px0 > qx0) ? px0 : qx0);
            ih = ((py1 < qy1) ? py1 : qy1) - ((py0 > qy0) ? py0 : qy0);
            if (iw < 0) iw = 0;
            if (ih < 0) ih = 0;
            inter = longint'(iw) * longint'(ih);
            uni   = area_p + area_q - inter;
            return (inter <<< 16) >= longint'(iou_limit) * uni;
        endfunction

        // Note one accepted candidate; close the set on its last flag
        function void note_box(t_box b);
            int    order[$];
            int    kept[$];
            int    j;
            int    slot;
            bit    hit;
            t_kept e;
            if (set_boxes.size() < BoxCapacity) set_boxes = {set_boxes, b};
            else dropped = 1;
            if (!b.last) return;
            // stable insertion sort, descending score
            for (int i = 0; i < set_boxes.size(); i++) begin
                order = {order, i};
                j = i;
                while (j > 0 && set_boxes[order[j-1]].score < set_boxes[i].score) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            // greedy walk in score order
            foreach (order[n]) begin
                if (kept.size() >= KeepMax) break;
                hit = 0;
                foreach (kept[k]) begin
                    if (suppresses(set_boxes[order[n]], set_boxes[kept[k]])) begin
                        hit = 1;
                        break;
                    end
                end
                if (!hit) kept = {kept, order[n]};
            end
            foreach (kept[k]) begin
                slot       = kept[k];
                e.ax       = set_boxes[slot].ax;
                e.ay       = set_boxes[slot].ay;
                e.bx       = set_boxes[slot].bx;
                e.by       = set_boxes[slot].by;
                e.score    = set_boxes[slot].score;
                e.angle    = set_boxes[slot].angle;
                e.overflow = dropped;
                e.last     = (k == kept.size() - 1);
                kept_due   = {kept_due, e};
            end
            set_boxes.delete();
            dropped = 0;
            sets_closed++;
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_kept(t_kept got);
            t_kept exp_k;
            kept_seen++;
            if (kept_due.size() == 0) begin
                $error("unexpected kept box ax=%0d ay=%0d", got.ax, got.ay);
                errors++;
                return;
            end
            exp_k = kept_due.pop_front();
            if (got.ax !== exp_k.ax) begin
                $error("out_ax expected %0d actual %0d", exp_k.ax, got.ax); errors++;
            end
            if (got.ay !== exp_k.ay) begin
                $error("out_ay expected %0d actual %0d", exp_k.ay, got.ay); errors++;
            end
            if (got.bx !== exp_k.bx) begin
                $error("out_bx expected %0d actual %0d", exp_k.bx, got.bx); errors++;
            end
            if (got.by !== exp_k.by) begin
                $error("out_by expected %0d actual %0d", exp_k.by, got.by); errors++;
            end
            if (got.score !== exp_k.score) begin
                $error("out_score expected %0d actual %0d", exp_k.score, got.score);
                errors++;
            end
            if (got.angle !== exp_k.angle) begin
                $error("out_angle expected %0d actual %0d", exp_k.angle, got.angle);
                errors++;
            end
            if (got.overflow !== exp_k.overflow) begin
                $error("overflow expected %0b actual %0b", exp_k.overflow, got.overflow);
                errors++;
            end
            if (got.last !== exp_k.last) begin
                $error("out_last expected %0b actual %0b", exp_k.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 3_000_000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [15:0]   i_cfg_data;
    gbs_box_if     box_ch ();
    gbs_kept_if    kept_ch ();
    nms_scoreboard sb;
    bit            quiet;
    bit            long_hold_done;
    int            boxes_sent;
    int            cycles;

    greedy_box_suppression_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_box      (box_ch.sink),
        .o_kept     (kept_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    // Random box clustered around a few centers so that overlaps are common
    function automatic t_box rand_box(bit last);
        t_box b;
        int   cx, cy, w, h;
        if ($urandom_range(0, 9) == 0) begin
            b.ax = rand_coord(); b.ay = rand_coord();
            b.bx = rand_coord(); b.by = rand_coord();
        end else begin
            cx = $urandom_range(0, 3) * 1500 - 2000;
            cy = $urandom_range(0, 3) * 1500 - 2000;
            w  = $urandom_range(0, 1600);
            h  = $urandom_range(0, 1600);
            if ($urandom_range(0, 15) == 0) w = 0;
            cx = cx + $urandom_range(0, 400);
            cy = cy + $urandom_range(0, 400);
            b.ax = 16'(cx); b.ay = 16'(cy);
            b.bx = 16'(cx + w); b.by = 16'(cy + h);
            if ($urandom_range(0, 1)) begin
                b.ax = 16'(cx + w); b.bx = 16'(cx);
            end
            if ($urandom_range(0, 1)) begin
                b.ay = 16'(cy + h); b.by = 16'(cy);
            end
        end
        case ($urandom_range(0, 7))
            0:       b.score = 16'($urandom_range(0, 3) * 8192);
            1:       b.score = 16'($urandom);
            default: b.score = 16'($urandom_range(0, 32768));
        endcase
        b.angle = 16'($urandom);
        b.last  = last;
        return b;
    endfunction

    // Offer one candidate and hold it until the transfer; the caller drops
    // valid, or the next call replaces the payload at the same falling edge
    task automatic send_box(t_box b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.corner_ax <= b.ax;
        box_ch.corner_ay <= b.ay;
        box_ch.corner_bx <= b.bx;
        box_ch.corner_by <= b.by;
        box_ch.box_score <= b.score;
        box_ch.box_angle <= b.angle;
        box_ch.load_last <= b.last;
        do @(posedge i_clk); while (!box_ch.ready);
        sb.note_box(b);
        boxes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_set(int n);
        for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1));
    endtask

    // Write the limit once every result is out and the block is idle
    task automatic write_limit(logic [15:0] value);
        box_ch.valid <= 1'b0;
        while (sb.kept_due.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.iou_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        kept_ch.ready  = 1'b0;
        long_hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb.sets_closed >= 8 && sb.kept_due.size() > 0) begin
                kept_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold_done = 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                kept_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                kept_ch.ready <= 1'b1;
            end
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        t_kept got;
        if (i_rst_n && kept_ch.valid && kept_ch.ready) begin
            got.ax       = kept_ch.out_ax;
            got.ay       = kept_ch.out_ay;
            got.bx       = kept_ch.out_bx;
            got.by       = kept_ch.out_by;
            got.score    = kept_ch.out_score;
            got.angle    = kept_ch.out_angle;
            got.overflow = kept_ch.overflow;
            got.last     = kept_ch.out_last;
            sb.check_kept(got);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_box b;
        int   n;
        sb             = new();
        quiet          = 0;
        boxes_sent     = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        box_ch.valid     = 1'b0;
        box_ch.corner_ax = '0;
        box_ch.corner_ay = '0;
        box_ch.corner_bx = '0;
        box_ch.corner_by = '0;
        box_ch.box_score = '0;
        box_ch.box_angle = '0;
        box_ch.load_last = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes, swapped corners, degenerate box, ties, wide score
        b = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd32768, 16'sh7FFF, 1'b0};
        send_box(b);
        b = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFF, 16'sh8000, 1'b0};
        send_box(b);
        b = '{16'sd100, 16'sd100, 16'sd100, 16'sd900, 16'd500, 16'sd0, 1'b0};
        send_box(b);
        b = '{16'sd0, 16'sd0, 16'sd1000, 16'sd1000, 16'd500, 16'sd1, 1'b0};
        send_box(b);
        b = '{16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 16'd500, 16'sd2, 1'b0};
        send_box(b);
        b = '{16'sd2000, 16'sd2000, 16'sd3000, 16'sd3000, 16'd0, -16'sd5, 1'b1};
        send_box(b);
        // single box set
        b = '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'd0, 16'sd0, 1'b1};
        send_box(b);

        // zero limit: only the top box survives
        write_limit(16'd0);
        send_random_set(6);
        // full limit: nearly nothing is suppressed
        write_limit(16'hFFFF);
        send_random_set(6);
        write_limit(IouLimitRst);

        // Random sets, mostly small
        while (boxes_sent < 160) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 30) : $urandom_range(1, 10);
            send_random_set(n);
            if ($urandom_range(0, 4) == 0) write_limit(16'($urandom));
        end

        // One set beyond capacity to drive the overflow path
        write_limit(16'd32768);
        send_random_set(BoxCapacity + 4);

        // Remaining sets, idling off in the last stretch
        write_limit(16'd19661);
        while (boxes_sent < 470) begin
            if (boxes_sent > 420) quiet = 1;
            send_random_set($urandom_range(1, 10));
            if (!quiet && $urandom_range(0, 5) == 0) write_limit(16'($urandom));
        end

        box_ch.valid <= 1'b0;
        while (sb.kept_due.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("covered %0d candidates in %0d sets, %0d kept boxes checked",
                 boxes_sent, sb.sets_closed, sb.kept_seen);
        $display("limits 0, default, one half, full scale and random; one overflow set");
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- greedy_box_suppression_core.f -----
hdl/gbs_pkg.sv
hdl/gbs_if.sv
hdl/gbs_ctrl.sv
hdl/gbs_datapath.sv
hdl/greedy_box_suppression_core.sv
verif/tb_greedy_box_suppression_core.sv
